>>> src/cspt_pkg.sv
`default_nettype none

package cspt_pkg;

	localparam int INPUT_WIDTH  = 32;
	localparam int TRAJ_WIDTH   = 64;
	localparam int STEP_WIDTH   = 12;
	localparam int MARGIN_WIDTH = 8;

	localparam logic [STEP_WIDTH-1:0] STEP_MAX = {STEP_WIDTH{1'b1}};

	// largest value whose 3x+1 still fits in the trajectory register
	localparam logic [TRAJ_WIDTH-1:0] TRAJ_ODD_LIMIT =
		({TRAJ_WIDTH{1'b1}} - TRAJ_WIDTH'(1)) / TRAJ_WIDTH'(3);

	localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = MARGIN_WIDTH'(2);

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_RUN,
		CORE_DONE
	} core_state_t;

	// finished count offered by the core to the output side
	typedef struct packed {
		logic                  valid;
		logic [STEP_WIDTH-1:0] steps;
	} core_res_t;

endpackage

`default_nettype wire

>>> src/cspt_core.sv
`default_nettype none

module cspt_core
	import cspt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [INPUT_WIDTH-1:0] start_value,
	input  wire logic                   res_ready,
	output logic                        idle,
	output core_res_t                   res
);

	core_state_t             state_q, state_d;
	logic [TRAJ_WIDTH-1:0]   x_q, x_d;
	logic [STEP_WIDTH-1:0]   steps_q, steps_d;
	logic [TRAJ_WIDTH:0]     triple;
	logic [STEP_WIDTH:0]     steps_p2;

	// 3x+1, always even for odd x; the halving is folded into the same cycle
	assign triple   = {1'b0, x_q} + {x_q, 1'b0} + (TRAJ_WIDTH+1)'(1);
	assign steps_p2 = {1'b0, steps_q} + (STEP_WIDTH+1)'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			steps_q <= '0;
		end else begin
			x_q     <= x_d;
			steps_q <= steps_d;
		end
	end

	always_comb begin
		state_d = state_q;
		x_d     = x_q;
		steps_d = steps_q;
		unique case (state_q)
			CORE_IDLE: begin
				if (start) begin
					x_d     = TRAJ_WIDTH'(start_value);
					steps_d = '0;
					state_d = CORE_RUN;
				end
			end
			CORE_RUN: begin
				if (x_q <= TRAJ_WIDTH'(1) || steps_q == STEP_MAX) begin
					state_d = CORE_DONE;
				end else if (!x_q[0]) begin
					x_d     = x_q >> 1;
					steps_d = steps_q + STEP_WIDTH'(1);
				end else if (x_q > TRAJ_ODD_LIMIT) begin
					// 3x+1 would overflow: report saturated count
					steps_d = STEP_MAX;
					state_d = CORE_DONE;
				end else begin
					x_d     = triple[TRAJ_WIDTH:1];
					steps_d = steps_p2[STEP_WIDTH] ? STEP_MAX : steps_p2[STEP_WIDTH-1:0];
				end
			end
			CORE_DONE: begin
				if (res_ready) begin
					state_d = CORE_IDLE;
				end
			end
			default: begin
				state_d = CORE_IDLE;
			end
		endcase
	end

	assign idle      = (state_q == CORE_IDLE);
	assign res.valid = (state_q == CORE_DONE);
	assign res.steps = steps_q;

endmodule

`default_nettype wire

>>> src/cspt_peak.sv
`default_nettype none

module cspt_peak
	import cspt_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    take,
	input  wire logic [STEP_WIDTH-1:0]   steps,
	input  wire logic [MARGIN_WIDTH-1:0] margin,
	output logic                         peak,
	output logic                         predictor
);

	logic [STEP_WIDTH-1:0] max_q;
	logic [STEP_WIDTH-1:0] margin_ext;
	logic [STEP_WIDTH-1:0] floor_val;
	logic                  near;

	assign margin_ext = STEP_WIDTH'(margin);
	assign floor_val  = max_q - margin_ext;
	assign peak       = steps > max_q;
	assign near       = (max_q >= margin_ext) && (steps >= floor_val);
	assign predictor  = near || peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (take && peak) begin
			max_q <= steps;
		end
	end

endmodule

`default_nettype wire

>>> src/collatz_steps_peak_tracker.sv
`default_nettype none

// Flow: the core iterates an accepted value until it is at most one or the count saturates,
// then hands the count to the output register (an odd step and its halving share the same cycle).
// A new value is accepted only once the core has handed its previous count to the output register.
// A finished count may wait in the output register while the next item runs.
// Reset: asynchronous, active low; running maximum cleared, near_margin = 2.

module collatz_steps_peak_tracker
	import cspt_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [INPUT_WIDTH-1:0]  start_value,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [STEP_WIDTH-1:0]        step_count,
	output logic                         is_peak,
	output logic                         is_predictor,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [MARGIN_WIDTH-1:0] cfg_data
);

	logic                    core_idle;
	logic                    res_ready;
	logic                    res_take;
	core_res_t               res;
	logic [MARGIN_WIDTH-1:0] margin_q;
	logic                    peak;
	logic                    predictor;
	logic                    out_valid_q;
	logic [STEP_WIDTH-1:0]   step_count_q;
	logic                    is_peak_q;
	logic                    is_predictor_q;

	assign in_ready  = core_idle;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg_valid) begin
			margin_q <= cfg_data;
		end
	end

	cspt_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_valid),
		.start_value (start_value),
		.res_ready   (res_ready),
		.idle        (core_idle),
		.res         (res)
	);

	assign res_ready = !out_valid_q || out_ready;
	assign res_take  = res.valid && res_ready;

	cspt_peak u_peak (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (res_take),
		.steps     (res.steps),
		.margin    (margin_q),
		.peak      (peak),
		.predictor (predictor)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			step_count_q   <= res.steps;
			is_peak_q      <= peak;
			is_predictor_q <= predictor;
		end
	end

	assign out_valid    = out_valid_q;
	assign step_count   = step_count_q;
	assign is_peak      = is_peak_q;
	assign is_predictor = is_predictor_q;

endmodule

`default_nettype wire

>>> test/collatz_steps_peak_tracker_tb.sv
`timescale 1ns / 100ps

module collatz_steps_peak_tracker_tb;
	import cspt_pkg::*;

	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int BATCH_ITEMS = 86;
	localparam logic [TRAJ_WIDTH-1:0] TRIPLE_LIMIT =
		({TRAJ_WIDTH{1'b1}} - TRAJ_WIDTH'(1)) / TRAJ_WIDTH'(3);

	typedef struct packed {
		logic [STEP_WIDTH-1:0] steps;
		logic                  peak;
		logic                  predictor;
	} collatz_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [INPUT_WIDTH-1:0]  start_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [STEP_WIDTH-1:0]   step_count;
	logic                    is_peak;
	logic                    is_predictor;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [MARGIN_WIDTH-1:0] cfg_data = '0;

	logic [INPUT_WIDTH-1:0]  start_q[$];
	logic [MARGIN_WIDTH-1:0] margin_q[$];
	collatz_result_t         expected_q[$];

	logic                    quiet = 1'b0;
	int                      in_gap = 0;
	int                      out_stall = 0;
	int                      cycle_count = 0;

	// predictor state
	int                      record_steps = 0;
	int                      margin_now = int'(MARGIN_RESET);

	int                      mismatches = 0;
	int                      items_done = 0;
	int                      peaks_seen = 0;
	int                      predictors_seen = 0;
	int                      margin_writes = 0;

	collatz_steps_peak_tracker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_value  (start_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.step_count   (step_count),
		.is_peak      (is_peak),
		.is_predictor (is_predictor),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// steps to reach one; odd steps that would overflow the trajectory saturate
	function automatic int collatz_steps(input logic [INPUT_WIDTH-1:0] start);
		logic [TRAJ_WIDTH-1:0] x;
		int                    n;
		x = TRAJ_WIDTH'(start);
		n = 0;
		while (x > 1 && n < int'(STEP_MAX)) begin
			if (!x[0]) begin
				x = x >> 1;
			end else if (x > TRIPLE_LIMIT) begin
				return int'(STEP_MAX);
			end else begin
				x = x * 3 + 1;
			end
			n++;
		end
		return n;
	endfunction

	function automatic logic [INPUT_WIDTH-1:0] pick_start();
		logic [63:0] r;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: r = 64'($urandom);
			4, 5, 6: r = 64'($urandom_range(0, 2000));
			7, 8: begin
				// long-trajectory starts, shifted left by up to four bits to land just above earlier counts
				case ($urandom_range(0, 7))
					0: r = 64'd27;
					1: r = 64'd871;
					2: r = 64'd77031;
					3: r = 64'd837799;
					4: r = 64'd8400511;
					5: r = 64'd63728127;
					6: r = 64'd670617279;
					default: r = 64'd1410123943;
				endcase
				r = r << $urandom_range(0, 4);
				if (r[63:INPUT_WIDTH] != 0)
					r = r >> 4;
			end
			default: begin
				if ($urandom_range(0, 1))
					r = 64'($urandom_range(0, 1));
				else
					r = 64'd1 << $urandom_range(0, INPUT_WIDTH - 1);
			end
		endcase
		return r[INPUT_WIDTH-1:0];
	endfunction

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (start_q.size() != 0) begin
				in_valid <= 1'b1;
				start_value <= start_q.pop_front();
				if (!quiet && $urandom_range(0, 3) == 0)
					in_gap = $urandom_range(1, 6);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// margin register writes
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (!cfg_valid || cfg_ready) begin
			if (margin_q.size() != 0) begin
				cfg_valid <= 1'b1;
				cfg_data <= margin_q.pop_front();
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(posedge clk) begin
		if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			out_stall = $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_q.size());
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin : result_check
		collatz_result_t want;
		int              steps;
		int              prev;
		logic            peak;
		logic            near;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				margin_now = int'(cfg_data);
				margin_writes++;
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: steps %0d peak %0b pred %0b",
							step_count, is_peak, is_predictor);
				end else begin
					want = expected_q.pop_front();
					items_done++;
					if (step_count !== want.steps || is_peak !== want.peak ||
						is_predictor !== want.predictor) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: want %0d/%0b/%0b, got %0d/%0b/%0b",
								items_done, want.steps, want.peak, want.predictor,
								step_count, is_peak, is_predictor);
					end
				end
			end
			if (in_valid && in_ready) begin
				steps = collatz_steps(start_value);
				prev = record_steps;
				peak = steps > prev;
				near = (prev >= margin_now) && (steps >= prev - margin_now);
				if (peak) begin
					record_steps = steps;
					peaks_seen++;
				end
				if (peak || near)
					predictors_seen++;
				want.steps = STEP_WIDTH'(steps);
				want.peak = peak;
				want.predictor = peak || near;
				expected_q.insert(expected_q.size(), want);
			end
		end
	end

	// sender holds off until every outstanding result has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (start_q.size() != 0 || in_valid || expected_q.size() != 0);
	endtask

	task automatic write_margin(input logic [MARGIN_WIDTH-1:0] m);
		@(negedge clk);
		margin_q.insert(margin_q.size(), m);
		do
			@(negedge clk);
		while (margin_q.size() != 0 || cfg_valid);
	endtask

	initial begin
		logic [MARGIN_WIDTH-1:0] margins[5];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset margin: zero/one, small records, an equal count, bit extremes
		start_q = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd6, 32'd5, 32'd14, 32'd7,
			32'd27, 32'd97, 32'd871, 32'd6171, 32'd77031, 32'd837799, 32'd8400511,
			32'd63728127, 32'd670617279, 32'd670617279, 32'h8000_0000,
			32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA};
		wait_drained();

		margins = '{8'd0, 8'd255, MARGIN_WIDTH'($urandom_range(1, 254)),
			MARGIN_WIDTH'($urandom_range(0, 255)), 8'd1};
		foreach (margins[p]) begin
			write_margin(margins[p]);
			if (p == 4)
				quiet = 1'b1;
			repeat (BATCH_ITEMS) start_q.insert(start_q.size(), pick_start());
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d results checked over %0d margin writes; record %0d steps",
			items_done, margin_writes, record_steps);
		$display("%0d new peaks, %0d predictor flags, %0d mismatches",
			peaks_seen, predictors_seen, mismatches);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
